/* src/bdlp_pkg.sv */
// Shared types and constants for the button debounce / long-press block.
// Used by bdlp_lane, bdlp_merge and button_debounce_long_press_core.
package bdlp_pkg;

  localparam int NUM_LANES   = 5;
  localparam int LANE_LEFT   = 0;
  localparam int LANE_SELECT = 2;

  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BACK_HOLD   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SELECT_HOLD = 2'd2;

  localparam logic [CFG_W-1:0] DEBOUNCE_RST    = 16'd50;
  localparam logic [CFG_W-1:0] BACK_HOLD_RST   = 16'd1500;
  localparam logic [CFG_W-1:0] SELECT_HOLD_RST = 16'd1000;

  // Event codes
  localparam logic [2:0] EV_NONE        = 3'd0;
  localparam logic [2:0] EV_LEFT        = 3'd1;
  localparam logic [2:0] EV_UP          = 3'd2;
  localparam logic [2:0] EV_SELECT      = 3'd3;
  localparam logic [2:0] EV_RIGHT       = 3'd4;
  localparam logic [2:0] EV_DOWN        = 3'd5;
  localparam logic [2:0] EV_LEFT_LONG   = 3'd6;
  localparam logic [2:0] EV_SELECT_LONG = 3'd7;

  // Pump request codes
  localparam logic [1:0] PUMP_NONE = 2'd0;
  localparam logic [1:0] PUMP_ON   = 2'd1;
  localparam logic [1:0] PUMP_OFF  = 2'd2;

  typedef struct packed {
    logic [31:0] now_ms;
    logic [4:0]  raw_buttons;
    logic        ui_editing;
    logic        timer_active;
    logic        pump_on;
  } in_t;

  typedef struct packed {
    logic [2:0] event_res;
    logic       timer_cancel;
    logic [1:0] pump_request;
    logic       force_manual;
  } out_t;

  // What one lane found in one sample
  typedef struct packed {
    logic short_ev;
    logic long_ev;
  } lane_ev_t;

endpackage

/* src/bdlp_lane.sv */
// One button lane: debouncer plus optional long-press timer.
// Depends on bdlp_pkg for lane_ev_t.
module bdlp_lane #(
  parameter int TIME_BITS = 32,
  parameter bit HAS_LONG  = 1'b0
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic [TIME_BITS-1:0]    now,
  input  logic                    lvl,
  input  logic [15:0]             debounce_ms,
  input  logic [15:0]             hold_ms,
  output bdlp_pkg::lane_ev_t      ev
);
  import bdlp_pkg::*;

  logic                 last_level_r, last_level_nxt;
  logic [TIME_BITS-1:0] edge_time_r, edge_time_nxt;
  logic                 stable_r, stable_nxt;
  logic [TIME_BITS-1:0] press_time_r, press_time_nxt;
  logic                 long_done_r, long_done_nxt;

  logic [TIME_BITS-1:0] edge_elapsed;
  logic [TIME_BITS-1:0] hold_elapsed;
  logic                 settle;
  logic                 ld_mid;

  // Track raw edges, debounce, then check hold time
  always_comb begin
    last_level_nxt = lvl;
    edge_time_nxt  = (lvl != last_level_r) ? now : edge_time_r;
    edge_elapsed   = now - edge_time_nxt;
    settle         = (lvl != stable_r) && (edge_elapsed >= TIME_BITS'(debounce_ms));

    stable_nxt     = settle ? lvl : stable_r;
    press_time_nxt = (settle && !lvl) ? now : press_time_r;
    ld_mid         = (settle && !lvl) ? 1'b0 : long_done_r;

    ev.short_ev    = settle && lvl && !long_done_r;

    hold_elapsed   = now - press_time_nxt;
    ev.long_ev     = HAS_LONG && !stable_nxt && !ld_mid &&
                     (hold_elapsed >= TIME_BITS'(hold_ms));
    long_done_nxt  = ld_mid || ev.long_ev;
  end

  // Advance lane state on each accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_level_r <= 1'b1;
      edge_time_r  <= '0;
      stable_r     <= 1'b1;
      press_time_r <= '0;
      long_done_r  <= 1'b0;
    end else if (en) begin
      last_level_r <= last_level_nxt;
      edge_time_r  <= edge_time_nxt;
      stable_r     <= stable_nxt;
      press_time_r <= press_time_nxt;
      long_done_r  <= long_done_nxt;
    end
  end

endmodule

/* src/bdlp_merge.sv */
// Merge stage: picks the winning lane event, builds select side outputs
// and holds the result beat. Depends on bdlp_pkg.
module bdlp_merge (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  logic                                         en,
  input  bdlp_pkg::lane_ev_t [bdlp_pkg::NUM_LANES-1:0] lane_ev,
  input  logic                                         ui_editing,
  input  logic                                         timer_active,
  input  logic                                         pump_on,
  input  logic                                         out_ready,
  output logic                                         out_valid,
  output bdlp_pkg::out_t                               out_data
);
  import bdlp_pkg::*;

  logic out_valid_r, out_valid_nxt;
  out_t out_data_r, out_data_nxt;
  logic sel_long;

  // Highest-numbered lane wins; within a lane long overrides short
  always_comb begin
    sel_long     = lane_ev[LANE_SELECT].long_ev;
    out_data_nxt = '0;
    if (lane_ev[4].short_ev) begin
      out_data_nxt.event_res = EV_DOWN;
    end else if (lane_ev[3].short_ev) begin
      out_data_nxt.event_res = EV_RIGHT;
    end else if (sel_long) begin
      out_data_nxt.event_res = EV_SELECT_LONG;
    end else if (lane_ev[LANE_SELECT].short_ev) begin
      out_data_nxt.event_res = EV_SELECT;
    end else if (lane_ev[1].short_ev) begin
      out_data_nxt.event_res = EV_UP;
    end else if (lane_ev[LANE_LEFT].long_ev) begin
      out_data_nxt.event_res = EV_LEFT_LONG;
    end else if (lane_ev[LANE_LEFT].short_ev) begin
      out_data_nxt.event_res = EV_LEFT;
    end else begin
      out_data_nxt.event_res = EV_NONE;
    end

    // Select long press side outputs, given even when the event is hidden
    if (sel_long && !ui_editing) begin
      if (timer_active) begin
        out_data_nxt.timer_cancel = 1'b1;
      end else begin
        out_data_nxt.pump_request = pump_on ? PUMP_OFF : PUMP_ON;
        out_data_nxt.force_manual = 1'b1;
      end
    end

    out_valid_nxt = en ? 1'b1 : (out_valid_r && !out_ready);
  end

  // Hold the result beat until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* src/button_debounce_long_press_core.sv */
// Top level: five debounce lanes, merge stage and configuration registers.
// Depends on bdlp_pkg, bdlp_lane and bdlp_merge.
//
//   Channel | Ports                          | Beat
//   --------+--------------------------------+---------------------------------
//   input   | in_valid, in_ready, in_data    | one sample: time, buttons, flags
//   result  | out_valid, out_ready, out_data | one event word per sample
//   config  | cfg_valid, cfg_ready, cfg_*    | one register write
//
// One sample per cycle; each result appears in the cycle after its sample is
// accepted, from the merge stage's output register. The lanes update their
// state in the accepting cycle. in_ready drops only while a result is held
// and out_ready is low. cfg_ready is always high. Synchronous reset clears
// lane state and loads the register defaults.
module button_debounce_long_press_core #(
  parameter int TIME_BITS = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  bdlp_pkg::in_t                      in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output bdlp_pkg::out_t                     out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [bdlp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bdlp_pkg::CFG_W-1:0]         cfg_data
);
  import bdlp_pkg::*;

  logic [CFG_W-1:0] debounce_r;
  logic [CFG_W-1:0] back_hold_r;
  logic [CFG_W-1:0] select_hold_r;

  logic                            accept;
  logic [TIME_BITS-1:0]            now;
  lane_ev_t [NUM_LANES-1:0]        lane_ev;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign accept    = in_valid && in_ready;
  assign now       = TIME_BITS'(in_data.now_ms);

  // Register writes; unknown indexes drop
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r    <= DEBOUNCE_RST;
      back_hold_r   <= BACK_HOLD_RST;
      select_hold_r <= SELECT_HOLD_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_DEBOUNCE:    debounce_r    <= cfg_data;
        CFG_BACK_HOLD:   back_hold_r   <= cfg_data;
        CFG_SELECT_HOLD: select_hold_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // One lane per button
  for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
    bdlp_lane #(
      .TIME_BITS (TIME_BITS),
      .HAS_LONG  ((i == LANE_LEFT) || (i == LANE_SELECT))
    ) u_lane (
      .clk         (clk),
      .rst_n       (rst_n),
      .en          (accept),
      .now         (now),
      .lvl         (in_data.raw_buttons[i]),
      .debounce_ms (debounce_r),
      .hold_ms     ((i == LANE_LEFT) ? back_hold_r : select_hold_r),
      .ev          (lane_ev[i])
    );
  end

  bdlp_merge u_merge (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (accept),
    .lane_ev      (lane_ev),
    .ui_editing   (in_data.ui_editing),
    .timer_active (in_data.timer_active),
    .pump_on      (in_data.pump_on),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .out_data     (out_data)
  );

endmodule

/* dv/button_debounce_long_press_core_test.sv */
// Self-checking test for button_debounce_long_press_core: drives sample and
// register beats, tracks expected press events in a small class.
// Depends on bdlp_pkg and the RTL under src/.
module button_debounce_long_press_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import bdlp_pkg::*;

  localparam int          ITEMS_PER_PHASE = 54;
  localparam int          STALL_CYCLES    = 60;
  localparam int          NUM_PHASES      = 7;
  localparam logic [2:0]  F_NONE          = 3'b000;
  localparam logic [2:0]  F_PUMP          = 3'b001;
  localparam logic [2:0]  F_TIMER         = 3'b010;
  localparam logic [2:0]  F_EDIT          = 3'b100;

  // Tracks per-lane debounce state and the queue of expected event words
  class press_tracker;
    logic [CFG_W-1:0] debounce_ms;
    logic [CFG_W-1:0] back_hold_ms;
    logic [CFG_W-1:0] select_hold_ms;
    logic             last_level  [NUM_LANES];
    logic [31:0]      edge_ms     [NUM_LANES];
    logic             stable_level[NUM_LANES];
    logic [31:0]      press_ms    [NUM_LANES];
    logic             long_done   [NUM_LANES];
    out_t             expected_events[$];
    int               mismatches;

    function new();
      int i;
      for (i = 0; i < NUM_LANES; i++) begin
        last_level[i]   = 1'b1;
        edge_ms[i]      = '0;
        stable_level[i] = 1'b1;
        press_ms[i]     = '0;
        long_done[i]    = 1'b0;
      end
      debounce_ms    = DEBOUNCE_RST;
      back_hold_ms   = BACK_HOLD_RST;
      select_hold_ms = SELECT_HOLD_RST;
      mismatches     = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        CFG_DEBOUNCE:    debounce_ms    = val;
        CFG_BACK_HOLD:   back_hold_ms   = val;
        CFG_SELECT_HOLD: select_hold_ms = val;
        default: ;
      endcase
    endfunction

    // Advance every lane by one sample and queue the event word it yields
    function void take_sample(in_t s);
      out_t        res;
      int          i;
      logic        lvl;
      logic [31:0] hold;
      logic [31:0] since_edge;
      logic [31:0] since_press;
      res = '0;
      for (i = 0; i < NUM_LANES; i++) begin
        lvl  = s.raw_buttons[i];
        hold = (i == LANE_LEFT) ? {16'h0, back_hold_ms} : {16'h0, select_hold_ms};
        if (lvl != last_level[i]) begin
          last_level[i] = lvl;
          edge_ms[i]    = s.now_ms;
        end
        since_edge = s.now_ms - edge_ms[i];
        if (lvl != stable_level[i] && since_edge >= {16'h0, debounce_ms}) begin
          stable_level[i] = lvl;
          if (!lvl) begin
            press_ms[i]  = s.now_ms;
            long_done[i] = 1'b0;
          end else if (!long_done[i]) begin
            res.event_res = EV_LEFT + 3'(i);
          end
        end
        since_press = s.now_ms - press_ms[i];
        if ((i == LANE_LEFT || i == LANE_SELECT) && !stable_level[i] && !long_done[i] &&
            since_press >= hold) begin
          long_done[i] = 1'b1;
          if (i == LANE_SELECT) begin
            res.event_res = EV_SELECT_LONG;
            if (s.ui_editing) begin
              // edit screen takes the event alone
            end else if (s.timer_active) begin
              res.timer_cancel = 1'b1;
            end else begin
              res.pump_request = s.pump_on ? PUMP_OFF : PUMP_ON;
              res.force_manual = 1'b1;
            end
          end else begin
            res.event_res = EV_LEFT_LONG;
          end
        end
      end
      expected_events.push_back(res);
    endfunction

    function void report(string field, logic [2:0] want, logic [2:0] got);
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
      mismatches++;
    endfunction

    function void check_event(out_t got);
      out_t want;
      if (expected_events.size() == 0) begin
        $display("%0t: unexpected result beat, expected none actual %h", $time, got);
        mismatches++;
        return;
      end
      want = expected_events.pop_front();
      if (got.event_res !== want.event_res)
        report("event_res", want.event_res, got.event_res);
      if (got.timer_cancel !== want.timer_cancel)
        report("timer_cancel", {2'b0, want.timer_cancel}, {2'b0, got.timer_cancel});
      if (got.pump_request !== want.pump_request)
        report("pump_request", {1'b0, want.pump_request}, {1'b0, got.pump_request});
      if (got.force_manual !== want.force_manual)
        report("force_manual", {2'b0, want.force_manual}, {2'b0, got.force_manual});
    endfunction

    function int pending();
      return expected_events.size();
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  in_t                  in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_t                 out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_DEBOUNCE;
  logic [CFG_W-1:0]     cfg_data  = '0;

  press_tracker         tracker   = new();
  logic                 calm      = 1'b0;
  int                   stall_req = 0;
  int                   stall_ack = 0;
  logic [31:0]          walk_ms;
  logic [4:0]           walk_raw  = 5'h1F;
  int unsigned          span;

  button_debounce_long_press_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Note accepted samples and check accepted results
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) tracker.take_sample(in_data);
      if (out_valid && out_ready) tracker.check_event(out_data);
    end
  end

  // Result side: random back-pressure, one long hold-off on request
  initial begin : receiver
    int held;
    forever begin
      @(posedge clk);
      if (stall_req != stall_ack) begin
        stall_ack = stall_req;
        out_ready <= 1'b0;
        for (held = 0; held < STALL_CYCLES; held++) @(posedge clk);
      end
      out_ready <= calm || ($urandom_range(0, 99) >= 10);
    end
  end

  function automatic in_t make_sample(logic [31:0] t, logic [4:0] raw, logic [2:0] flags);
    in_t s;
    s.now_ms       = t;
    s.raw_buttons  = raw;
    s.ui_editing   = flags[2];
    s.timer_active = flags[1];
    s.pump_on      = flags[0];
    return s;
  endfunction

  // Offer one sample beat and hold it until accepted
  task automatic send_sample(in_t s);
    int gap;
    if (!calm && $urandom_range(0, 99) < 10) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 3);
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= s;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    tracker.set_reg(idx, val);
  endtask

  // Stop offering samples and wait until every expected result is back
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  task automatic apply_setting(logic [CFG_W-1:0] deb, logic [CFG_W-1:0] back,
                               logic [CFG_W-1:0] sel);
    int unsigned top;
    drain_results();
    write_reg(CFG_DEBOUNCE, deb);
    write_reg(CFG_BACK_HOLD, back);
    write_reg(CFG_SELECT_HOLD, sel);
    cfg_valid <= 1'b0;
    top = 32'(deb);
    if (32'(back) > top) top = 32'(back);
    if (32'(sel) > top) top = 32'(sel);
    span = top / 3 + 4;
  endtask

  // Random walk: mostly steady holds and presses, some bounce and time jumps
  task automatic run_random(int count);
    int n;
    int pick;
    int bit_idx;
    logic [2:0] flags;
    for (n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        walk_ms = walk_ms + $urandom_range(0, span);
        if ($urandom_range(0, 99) < 30) begin
          bit_idx = $urandom_range(0, NUM_LANES - 1);
          walk_raw[bit_idx] = ~walk_raw[bit_idx];
        end
      end else if (pick < 85) begin
        walk_ms = walk_ms + $urandom_range(0, 3);
        if ($urandom_range(0, 1) == 1) begin
          bit_idx = $urandom_range(0, NUM_LANES - 1);
          walk_raw[bit_idx] = ~walk_raw[bit_idx];
        end
      end else if (pick < 95) begin
        walk_ms = walk_ms + $urandom_range(0, 4 * span);
      end else begin
        walk_ms = $urandom;
      end
      if ($urandom_range(0, 99) < 4) walk_raw = 5'($urandom_range(0, 31));
      flags[2] = ($urandom_range(0, 3) == 0);
      flags[1] = ($urandom_range(0, 2) == 0);
      flags[0] = 1'($urandom_range(0, 1));
      send_sample(make_sample(walk_ms, walk_raw, flags));
    end
  endtask

  // Press sequences at the reset timing: 50 ms debounce, 1500/1000 ms holds
  task automatic directed_part();
    send_sample(make_sample(32'd0,    5'h1F, F_NONE));
    send_sample(make_sample(32'd10,   5'h1D, F_NONE));
    send_sample(make_sample(32'd60,   5'h1D, F_NONE));
    send_sample(make_sample(32'd70,   5'h1F, F_NONE));
    send_sample(make_sample(32'd120,  5'h1F, F_NONE));
    // all pressed, then select long with pump on, then left long
    send_sample(make_sample(32'd130,  5'h00, F_NONE));
    send_sample(make_sample(32'd180,  5'h00, F_NONE));
    send_sample(make_sample(32'd1180, 5'h00, F_PUMP));
    send_sample(make_sample(32'd1680, 5'h00, F_NONE));
    send_sample(make_sample(32'd1700, 5'h1F, F_NONE));
    send_sample(make_sample(32'd1750, 5'h1F, F_NONE));
    // select long while the timer runs
    send_sample(make_sample(32'd1800, 5'h1B, F_NONE));
    send_sample(make_sample(32'd1850, 5'h1B, F_NONE));
    send_sample(make_sample(32'd2850, 5'h1B, F_TIMER | F_PUMP));
    send_sample(make_sample(32'd2900, 5'h1F, F_NONE));
    send_sample(make_sample(32'd2950, 5'h1F, F_EDIT));
    // down release hides a select long press in the same sample
    send_sample(make_sample(32'd3000, 5'h0A, F_NONE));
    send_sample(make_sample(32'd3050, 5'h0A, F_NONE));
    send_sample(make_sample(32'd4000, 5'h1A, F_NONE));
    send_sample(make_sample(32'd4050, 5'h1A, F_NONE));
    send_sample(make_sample(32'd4550, 5'h1A, F_EDIT));
    send_sample(make_sample(32'd4600, 5'h1F, F_NONE));
    send_sample(make_sample(32'd4650, 5'h1F, F_NONE));
    // press across the time wrap
    send_sample(make_sample(32'hFFFF_FFF0, 5'h1E, F_NONE));
    send_sample(make_sample(32'h0000_0030, 5'h1E, F_NONE));
  endtask

  initial begin : stimulus
    logic [CFG_W-1:0] deb_set [NUM_PHASES];
    logic [CFG_W-1:0] back_set[NUM_PHASES];
    logic [CFG_W-1:0] sel_set [NUM_PHASES];
    int p;
    deb_set  = '{16'd0, 16'hFFFF, 16'd50,   16'd1, 16'd0, 16'd0,    16'hFFFF};
    back_set = '{16'd0, 16'hFFFF, 16'd1500, 16'd1, 16'd0, 16'hFFFF, 16'd1};
    sel_set  = '{16'd0, 16'hFFFF, 16'd1000, 16'd1, 16'd0, 16'd1,    16'd0};
    walk_ms = 32'd0;
    span    = 1500 / 3 + 4;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    directed_part();
    for (p = 0; p < NUM_PHASES; p++) begin
      if (p == 4) begin
        deb_set[p]  = 16'($urandom_range(0, 65535));
        back_set[p] = 16'($urandom_range(0, 65535));
        sel_set[p]  = 16'($urandom_range(0, 65535));
      end
      apply_setting(deb_set[p], back_set[p], sel_set[p]);
      walk_ms = $urandom;
      calm = (p == 3);
      if (p == 2) stall_req++;
      if (p == 4) begin
        run_random(ITEMS_PER_PHASE / 2);
        drain_results();
        run_random(ITEMS_PER_PHASE - ITEMS_PER_PHASE / 2);
      end else begin
        run_random(ITEMS_PER_PHASE);
      end
    end
    calm = 1'b0;
    drain_results();
    repeat (4) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("[button_debounce_long_press_core] OK");
    end else begin
      $display("[button_debounce_long_press_core] ERROR");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #1_000_000;
    $display("[button_debounce_long_press_core] ERROR");
    $finish;
  end

endmodule

/* sim.f */
src/bdlp_pkg.sv
src/bdlp_lane.sv
src/bdlp_merge.sv
src/button_debounce_long_press_core.sv
dv/button_debounce_long_press_core_test.sv
